[rtl/pcf_pkg.sv]
package pcf_pkg;

   localparam int LEVEL_W = 4;
   localparam int WORD_W  = 10;

   localparam logic [1:0] FUNC_READ   = 2'd0;
   localparam logic [1:0] FUNC_WRITE  = 2'd1;
   localparam logic [1:0] FUNC_SAMPLE = 2'd2;

   localparam logic [WORD_W-1:0] W_CONFIG = 10'h000;
   localparam logic [WORD_W-1:0] W_CTL    = 10'h001;
   localparam logic [WORD_W-1:0] W_THRESH = 10'h002;
   localparam logic [WORD_W-1:0] W_LEVEL  = 10'h003;
   localparam logic [WORD_W-1:0] W_ERROR  = 10'h004;
   localparam logic [WORD_W-1:0] W_WARN   = 10'h005;
   localparam logic [WORD_W-1:0] W_DETECT = 10'h006;
   localparam logic [WORD_W-1:0] W_IRQEN  = 10'h007;
   localparam logic [WORD_W-1:0] W_OUT01  = 10'h008;
   localparam logic [WORD_W-1:0] W_PORT   = 10'h009;
   localparam logic [WORD_W-1:0] W_OUT45  = 10'h00A;
   localparam logic [WORD_W-1:0] W_OUT67  = 10'h00B;

   localparam int CFG_CLEAR_BIT = 31;
   localparam int CTL_DMA_BIT   = 24;

   typedef struct packed {
      logic clear;
      logic capture;
      logic execute;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
   } status_type;

endpackage

[rtl/pdm_capture_fifo_registers.sv]
// Microphone capture FIFO behind a 4 KB register window. After reset the block
// zeroes its register memory one word per cycle, all REG_WORDS words, with busy
// high, before it takes its first request. A request is taken on a clock edge
// with start high and busy low; the register memory is read in that cycle, the
// request executes in the next (busy high), and its result is shown on the rsp_
// ports for exactly one cycle after that, marked by rsp_valid. A request thus
// passes through a capture and an execute state, as set by the read-then-merge
// access to the single-port register memory, and a new request may be started
// while the previous result is on the ports. The receiver cannot stall: a result
// must be taken in the cycle it appears.
module pdm_capture_fifo_registers #(
   parameter int FIFO_DEPTH = 8,
   parameter int REG_WORDS  = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_func,
   input  logic [11:0]        req_addr,
   input  logic [2:0]         req_size,
   input  logic [31:0]        req_wdata,
   input  logic signed [15:0] req_sample,
   output logic               rsp_valid,
   output logic [31:0]        rsp_rdata,
   output logic               rsp_irq,
   output logic               rsp_dma_stall
);
   import pcf_pkg::*;

   cmd_type    cmd;
   status_type status;

   pcf_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   pcf_datapath #(
      .FIFO_DEPTH (FIFO_DEPTH),
      .REG_WORDS  (REG_WORDS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_func      (req_func),
      .req_addr      (req_addr),
      .req_size      (req_size),
      .req_wdata     (req_wdata),
      .req_sample    (req_sample),
      .rsp_valid     (rsp_valid),
      .rsp_rdata     (rsp_rdata),
      .rsp_irq       (rsp_irq),
      .rsp_dma_stall (rsp_dma_stall)
   );

endmodule

[rtl/pcf_ctrl.sv]
module pcf_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  pcf_pkg::status_type status,
   output pcf_pkg::cmd_type    cmd
);
   import pcf_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_EXEC  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy        = (state_ff != ST_IDLE);
   assign cmd.clear   = (state_ff == ST_CLEAR);
   assign cmd.capture = (state_ff == ST_IDLE) && start;
   assign cmd.execute = (state_ff == ST_EXEC);

endmodule

[rtl/pcf_datapath.sv]
module pcf_datapath #(
   parameter int FIFO_DEPTH = 8,
   parameter int REG_WORDS  = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  pcf_pkg::cmd_type    cmd,
   output pcf_pkg::status_type status,
   input  logic [1:0]          req_func,
   input  logic [11:0]         req_addr,
   input  logic [2:0]          req_size,
   input  logic [31:0]         req_wdata,
   input  logic signed [15:0]  req_sample,
   output logic                rsp_valid,
   output logic [31:0]         rsp_rdata,
   output logic                rsp_irq,
   output logic                rsp_dma_stall
);
   import pcf_pkg::*;

   localparam int AW   = $clog2(REG_WORDS);
   localparam int PW   = $clog2(FIFO_DEPTH);
   localparam int HALF = FIFO_DEPTH / 2;

   logic [31:0] reg_mem [REG_WORDS];
   logic [15:0] fifo_mem [FIFO_DEPTH];

   logic [AW-1:0]      clr_ff;
   logic [1:0]         func_ff;
   logic [11:0]        addr_ff;
   logic [2:0]         size_ff;
   logic [31:0]        wdata_ff;
   logic [15:0]        sample_ff;
   logic [31:0]        mem_rdata_ff;

   logic [31:0]        config_ff, config_in;
   logic [31:0]        ctl_ff, ctl_in;
   logic [31:0]        thresh_ff, thresh_in;
   logic [31:0]        irqen_ff, irqen_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic [PW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [PW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [15:0]        last_ff, last_in;
   logic               owed_ff, owed_in;
   logic               ovf_ff, ovf_in;
   logic               rsp_valid_ff;
   logic [31:0]        rsp_rdata_ff, rsp_rdata_in;
   logic               rsp_irq_ff, rsp_irq_in;
   logic               rsp_dma_stall_ff, rsp_dma_stall_in;

   logic [WORD_W-1:0]  word;
   logic [4:0]         shamt;
   logic               in_range;
   logic [31:0]        lanes;
   logic [31:0]        mask;
   logic [31:0]        base;
   logic [31:0]        merged;
   logic [31:0]        ret;
   logic               warn;
   logic               do_pop;
   logic               push;
   logic               mem_we;
   logic [15:0]        head;
   logic [15:0]        pop_val;
   logic               ge_in;
   logic [LEVEL_W:0]   wr_sum;
   logic [LEVEL_W:0]   wr_expect;

   function automatic logic [LEVEL_W-1:0] wm_of(input logic [3:0] t);
      if (t == 4'd0 || t > LEVEL_W'(FIFO_DEPTH)) begin
         return LEVEL_W'(HALF);
      end
      return t;
   endfunction

   function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
      if (p == PW'(FIFO_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   assign word     = addr_ff[11:2];
   assign shamt    = {addr_ff[1:0], 3'b000};
   assign in_range = {1'b0, word} < (WORD_W + 1)'(REG_WORDS);
   assign head     = fifo_mem[rd_ptr_ff];
   assign pop_val  = (level_ff != '0) ? head : last_ff;
   assign warn     = (config_ff[7:0] != 8'd0) && (level_ff >= wm_of(thresh_ff[3:0]));

   always_comb begin
      case (size_ff[1:0])
         2'd0:    lanes = 32'h0000_0000;
         2'd1:    lanes = 32'h0000_00FF;
         2'd2:    lanes = 32'h0000_FFFF;
         default: lanes = 32'h00FF_FFFF;
      endcase
      mask = size_ff[2] ? 32'hFFFF_FFFF : lanes;
   end

   always_comb begin
      unique case (word)
         W_CONFIG: base = config_ff;
         W_CTL:    base = ctl_ff;
         W_THRESH: base = thresh_ff;
         W_IRQEN:  base = irqen_ff;
         default:  base = in_range ? mem_rdata_ff : 32'd0;
      endcase
      if (size_ff[2]) begin
         merged = wdata_ff;
      end else begin
         merged = (base & ~(lanes << shamt)) | ((wdata_ff & lanes) << shamt);
      end
   end

   always_comb begin
      config_in    = config_ff;
      ctl_in       = ctl_ff;
      thresh_in    = thresh_ff;
      irqen_in     = irqen_ff;
      level_in     = level_ff;
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      last_in      = last_ff;
      owed_in      = owed_ff;
      ovf_in       = ovf_ff;
      do_pop       = 1'b0;
      push         = 1'b0;
      mem_we       = 1'b0;
      ret          = 32'd0;
      rsp_rdata_in = 32'd0;
      case (func_ff)
         FUNC_READ: begin
            unique case (word) inside
               W_LEVEL: ret = 32'(level_ff);
               W_ERROR: begin
                  ret    = {31'd0, ovf_ff};
                  ovf_in = 1'b0;
               end
               W_WARN:   ret = {31'd0, warn};
               W_DETECT: ret = 32'd0;
               W_OUT01, W_OUT45, W_OUT67: ret = {last_ff, last_ff};
               W_PORT:   ret = 32'd0;
               default:  ret = base;
            endcase
            if (word == W_PORT) begin
               if (size_ff[2]) begin
                  owed_in      = 1'b0;
                  do_pop       = 1'b1;
                  rsp_rdata_in = {pop_val, pop_val};
               end else if (addr_ff[1]) begin
                  rsp_rdata_in = {16'd0, last_ff} & mask;
               end else if (owed_ff) begin
                  owed_in      = 1'b0;
                  rsp_rdata_in = {16'd0, last_ff} & mask;
               end else begin
                  owed_in      = 1'b1;
                  do_pop       = 1'b1;
                  rsp_rdata_in = {16'd0, pop_val} & mask;
               end
            end else begin
               rsp_rdata_in = (ret >> shamt) & mask;
            end
         end
         FUNC_WRITE: begin
            unique case (word) inside
               W_CONFIG: begin
                  if (merged[CFG_CLEAR_BIT]) begin
                     level_in  = '0;
                     wr_ptr_in = rd_ptr_ff;
                     owed_in   = 1'b0;
                  end else begin
                     config_in = merged;
                  end
               end
               W_CTL:    ctl_in    = merged;
               W_THRESH: thresh_in = merged;
               W_IRQEN:  irqen_in  = merged;
               W_LEVEL, W_ERROR, W_WARN, W_DETECT,
               W_OUT01, W_PORT, W_OUT45, W_OUT67: mem_we = 1'b0;
               default:  mem_we = in_range;
            endcase
         end
         FUNC_SAMPLE: begin
            if (config_ff[7:0] != 8'd0) begin
               if (level_ff >= LEVEL_W'(FIFO_DEPTH)) begin
                  ovf_in = 1'b1;
               end else begin
                  push      = 1'b1;
                  wr_ptr_in = ptr_inc(wr_ptr_ff);
                  level_in  = level_ff + 1'b1;
               end
            end
         end
         default: begin
            ret = 32'd0;
         end
      endcase
      if (do_pop && level_ff != '0) begin
         last_in   = head;
         rd_ptr_in = ptr_inc(rd_ptr_ff);
         level_in  = level_ff - 1'b1;
      end
      ge_in            = level_in >= wm_of(thresh_in[3:0]);
      rsp_irq_in       = (irqen_in[0] && (config_in[7:0] != 8'd0) && ge_in) ||
                         (irqen_in[1] && ovf_in);
      rsp_dma_stall_in = !(ctl_in[CTL_DMA_BIT] && ge_in);
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         reg_mem[clr_ff] <= 32'd0;
      end else if (cmd.execute && mem_we) begin
         reg_mem[word[AW-1:0]] <= merged;
      end
      if (cmd.capture) begin
         mem_rdata_ff <= reg_mem[req_addr[AW+1:2]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute && push) begin
         fifo_mem[wr_ptr_ff] <= sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff   <= req_func;
         addr_ff   <= req_addr;
         size_ff   <= req_size;
         wdata_ff  <= req_wdata;
         sample_ff <= req_sample;
      end
      if (cmd.execute) begin
         rsp_rdata_ff     <= rsp_rdata_in;
         rsp_irq_ff       <= rsp_irq_in;
         rsp_dma_stall_ff <= rsp_dma_stall_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         config_ff    <= 32'd0;
         ctl_ff       <= 32'd0;
         thresh_ff    <= 32'd0;
         irqen_ff     <= 32'd0;
         level_ff     <= '0;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         last_ff      <= 16'd0;
         owed_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.execute;
         if (cmd.clear) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.execute) begin
            config_ff <= config_in;
            ctl_ff    <= ctl_in;
            thresh_ff <= thresh_in;
            irqen_ff  <= irqen_in;
            level_ff  <= level_in;
            rd_ptr_ff <= rd_ptr_in;
            wr_ptr_ff <= wr_ptr_in;
            last_ff   <= last_in;
            owed_ff   <= owed_in;
            ovf_ff    <= ovf_in;
         end
      end
   end

   assign status.clear_last = (clr_ff == AW'(REG_WORDS - 1));
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_rdata         = rsp_rdata_ff;
   assign rsp_irq           = rsp_irq_ff;
   assign rsp_dma_stall     = rsp_dma_stall_ff;

   assign wr_sum    = {1'b0, LEVEL_W'(rd_ptr_ff)} + {1'b0, level_ff};
   assign wr_expect = (wr_sum >= (LEVEL_W + 1)'(FIFO_DEPTH)) ?
                      wr_sum - (LEVEL_W + 1)'(FIFO_DEPTH) : wr_sum;

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LEVEL_W'(FIFO_DEPTH))
      else $error("FIFO level exceeds its depth.");

   a_ptr_consistent: assert property (@(posedge clock) disable iff (reset)
      wr_ptr_ff == PW'(wr_expect))
      else $error("FIFO write pointer disagrees with read pointer and level.");

   a_level_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.execute |=> $stable(level_ff))
      else $error("FIFO level changed outside request execution.");

endmodule

[dv/tb_pdm_capture_fifo_registers.sv]
`timescale 1ns / 1ps

module tb_pdm_capture_fifo_registers;
   import pcf_pkg::*;

   localparam int FIFO_DEPTH    = 8;
   localparam int REG_WORDS     = 1024;
   localparam int RANDOM_ITEMS  = 2000;
   localparam int IDLE_LIMIT    = 4000;
   localparam int DRAIN_CYCLES  = 8;
   localparam int PRINT_LIMIT   = 50;

   localparam logic [1:0] FUNC_NONE = 2'd3;

   typedef struct packed {
      logic [31:0] rdata;
      logic        irq;
      logic        stall;
   } capture_rsp_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [11:0] addr;
      logic [2:0]  size;
      logic [31:0] wdata;
      logic [15:0] smp;
      logic        typed;
      logic [31:0] exp_rdata;
      logic        exp_irq;
      logic        exp_stall;
   } step_row_type;

   localparam int DIRECTED_ROWS = 28;
   localparam step_row_type DIRECTED_TABLE [DIRECTED_ROWS] = '{
      '{FUNC_READ,   {W_CONFIG, 2'd0}, 3'd4, 32'h0000_0000, 16'h0000, 1'b1, 32'h0, 1'b0, 1'b1},
      '{FUNC_READ,   {W_PORT, 2'd0},   3'd4, 32'h0000_0000, 16'h0000, 1'b1, 32'h0, 1'b0, 1'b1},
      '{FUNC_WRITE,  {W_IRQEN, 2'd0},  3'd4, 32'h0000_0003, 16'h0000, 1'b1, 32'h0, 1'b0, 1'b1},
      '{FUNC_WRITE,  {W_CTL, 2'd0},    3'd4, 32'h0100_0000, 16'h0000, 1'b1, 32'h0, 1'b0, 1'b1},
      '{FUNC_WRITE,  {W_THRESH, 2'd0}, 3'd4, 32'h0000_000F, 16'h0000, 1'b1, 32'h0, 1'b0, 1'b1},
      '{FUNC_SAMPLE, 12'h000,          3'd0, 32'h0000_0000, 16'h1234, 1'b0, 32'h0, 1'b0, 1'b0},
      '{FUNC_WRITE,  {W_CONFIG, 2'd0}, 3'd1, 32'hFFFF_FF01, 16'h0000, 1'b0, 32'h0, 1'b0, 1'b0},
      '{FUNC_SAMPLE, 12'hFFF,          3'd7, 32'hFFFF_FFFF, 16'h8000, 1'b0, 32'h0, 1'b0, 1'b0},
      '{FUNC_SAMPLE, 12'h000,          3'd1, 32'h0000_0000, 16'h7FFF, 1'b0, 32'h0, 1'b0, 1'b0},
      '{FUNC_SAMPLE, 12'h000,          3'd2, 32'h0000_0000, 16'hFFFF, 1'b0, 32'h0, 1'b0, 1'b0},
      '{FUNC_SAMPLE, 12'h000,          3'd4, 32'h0000_0000, 16'h0000, 1'b0, 32'h0, 1'b0, 1'b0},
      '{FUNC_SAMPLE, 12'h000,          3'd4, 32'h0000_0000, 16'h5555, 1'b0, 32'h0, 1'b0, 1'b0},
      '{FUNC_SAMPLE, 12'h000,          3'd4, 32'h0000_0000, 16'hAAAA, 1'b0, 32'h0, 1'b0, 1'b0},
      '{FUNC_SAMPLE, 12'h000,          3'd4, 32'h0000_0000, 16'h0001, 1'b0, 32'h0, 1'b0, 1'b0},
      '{FUNC_SAMPLE, 12'h000,          3'd4, 32'h0000_0000, 16'h1234, 1'b0, 32'h0, 1'b0, 1'b0},
      '{FUNC_SAMPLE, 12'h000,          3'd4, 32'h0000_0000, 16'h4321, 1'b0, 32'h0, 1'b0, 1'b0},
      '{FUNC_READ,   {W_ERROR, 2'd0},  3'd4, 32'h0000_0000, 16'h0000, 1'b1, 32'h1, 1'b1, 1'b0},
      '{FUNC_READ,   {W_PORT, 2'd0},   3'd2, 32'h0000_0000, 16'h0000, 1'b0, 32'h0, 1'b0, 1'b0},
      '{FUNC_READ,   {W_PORT, 2'd2},   3'd2, 32'h0000_0000, 16'h0000, 1'b0, 32'h0, 1'b0, 1'b0},
      '{FUNC_READ,   {W_PORT, 2'd0},   3'd1, 32'h0000_0000, 16'h0000, 1'b0, 32'h0, 1'b0, 1'b0},
      '{FUNC_READ,   {W_PORT, 2'd0},   3'd4, 32'h0000_0000, 16'h0000, 1'b0, 32'h0, 1'b0, 1'b0},
      '{FUNC_READ,   {W_OUT45, 2'd1},  3'd3, 32'h0000_0000, 16'h0000, 1'b0, 32'h0, 1'b0, 1'b0},
      '{FUNC_WRITE,  12'hFFD,          3'd3, 32'hFFFF_FFFF, 16'h0000, 1'b0, 32'h0, 1'b0, 1'b0},
      '{FUNC_READ,   12'hFFC,          3'd7, 32'h0000_0000, 16'h0000, 1'b0, 32'h0, 1'b0, 1'b0},
      '{FUNC_NONE,   12'hFFF,          3'd0, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 32'h0, 1'b0, 1'b0},
      '{FUNC_WRITE,  12'hFF0,          3'd0, 32'hFFFF_FFFF, 16'h0000, 1'b0, 32'h0, 1'b0, 1'b0},
      '{FUNC_WRITE,  {W_CONFIG, 2'd0}, 3'd4, 32'h8000_00FF, 16'h0000, 1'b0, 32'h0, 1'b0, 1'b0},
      '{FUNC_READ,   {W_LEVEL, 2'd0},  3'd4, 32'h0000_0000, 16'h0000, 1'b1, 32'h0, 1'b0, 1'b1}
   };

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_func;
   logic [11:0]        req_addr;
   logic [2:0]         req_size;
   logic [31:0]        req_wdata;
   logic signed [15:0] req_sample;
   logic               rsp_valid;
   logic [31:0]        rsp_rdata;
   logic               rsp_irq;
   logic               rsp_dma_stall;

   logic               row_typed;
   capture_rsp_type    row_exp;

   logic [31:0]        reg_img [REG_WORDS];
   logic [15:0]        fifo_img [$];
   logic [15:0]        last_pop;
   bit                 half_owed;
   bit                 overflow_flag;

   capture_rsp_type    rsp_expect_q [$];
   int unsigned        sender_idle_pct;
   int unsigned        mismatch_count;
   int unsigned        idle_cycles;
   int unsigned        requests_taken;
   int unsigned        results_checked;
   int unsigned        reads_seen;
   int unsigned        writes_seen;
   int unsigned        samples_seen;
   int unsigned        pushes_done;
   int unsigned        pops_done;
   int unsigned        drops_done;

   pdm_capture_fifo_registers #(
      .FIFO_DEPTH(FIFO_DEPTH),
      .REG_WORDS (REG_WORDS)
   ) i_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_func     (req_func),
      .req_addr     (req_addr),
      .req_size     (req_size),
      .req_wdata    (req_wdata),
      .req_sample   (req_sample),
      .rsp_valid    (rsp_valid),
      .rsp_rdata    (rsp_rdata),
      .rsp_irq      (rsp_irq),
      .rsp_dma_stall(rsp_dma_stall)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit capture_running();
      return reg_img[W_CONFIG][7:0] != 8'h00;
   endfunction

   function automatic int unsigned watermark_level();
      int unsigned wm;
      wm = reg_img[W_THRESH][3:0];
      if (wm == 0 || wm > FIFO_DEPTH) wm = FIFO_DEPTH / 2;
      return wm;
   endfunction

   function automatic logic [15:0] pop_sample();
      if (fifo_img.size() != 0) begin
         last_pop = fifo_img.pop_front();
         pops_done++;
      end
      return last_pop;
   endfunction

   function automatic capture_rsp_type predict_capture(input logic [1:0] func,
                                                       input logic [11:0] addr,
                                                       input logic [2:0] size,
                                                       input logic [31:0] wdata,
                                                       input logic [15:0] smp);
      capture_rsp_type res;
      logic [9:0]      word;
      int unsigned     shift;
      logic [31:0]     size_mask;
      logic [31:0]     value;
      logic [31:0]     lanes;
      logic [31:0]     merged;
      logic [31:0]     irq_en;
      int unsigned     wm;
      int unsigned     level;
      bit              from_port;

      word      = addr[11:2];
      shift     = addr[1:0] * 8;
      size_mask = (size >= 3'd4) ? 32'hFFFF_FFFF : (32'h1 << (size * 8)) - 32'h1;
      res.rdata = 32'h0;
      from_port = 1'b0;
      value     = 32'h0;

      case (func)
         FUNC_READ: begin
            reads_seen++;
            case (word)
               W_LEVEL:  value = fifo_img.size();
               W_ERROR: begin
                  value = {31'h0, overflow_flag};
                  overflow_flag = 1'b0;
               end
               W_WARN:   value = {31'h0, capture_running() &&
                                          fifo_img.size() >= watermark_level()};
               W_DETECT: value = 32'h0;
               W_OUT01, W_OUT45, W_OUT67: value = {last_pop, last_pop};
               W_PORT: begin
                  from_port = 1'b1;
                  if (size >= 3'd4) begin
                     half_owed = 1'b0;
                     value = {2{pop_sample()}};
                  end else if (addr[1]) begin
                     value = {16'h0, last_pop};
                  end else if (half_owed) begin
                     half_owed = 1'b0;
                     value = {16'h0, last_pop};
                  end else begin
                     half_owed = 1'b1;
                     value = {16'h0, pop_sample()};
                  end
               end
               default:  value = reg_img[word];
            endcase
            if (!from_port) value = value >> shift;
            res.rdata = value & size_mask;
         end
         FUNC_WRITE: begin
            writes_seen++;
            merged = reg_img[word];
            if (size >= 3'd4) begin
               merged = wdata;
            end else begin
               lanes  = (32'h1 << (size * 8)) - 32'h1;
               merged = (merged & ~(lanes << shift)) | ((wdata & lanes) << shift);
            end
            case (word)
               W_CONFIG: begin
                  if (merged[CFG_CLEAR_BIT]) begin
                     fifo_img.delete();
                     half_owed = 1'b0;
                  end else begin
                     reg_img[W_CONFIG] = merged;
                  end
               end
               W_LEVEL, W_ERROR, W_WARN, W_DETECT, W_OUT01, W_PORT, W_OUT45, W_OUT67: ;
               default: reg_img[word] = merged;
            endcase
         end
         FUNC_SAMPLE: begin
            samples_seen++;
            if (capture_running()) begin
               if (fifo_img.size() >= FIFO_DEPTH) begin
                  overflow_flag = 1'b1;
                  drops_done++;
               end else begin
                  fifo_img.push_back(smp);
                  pushes_done++;
               end
            end
         end
         default: ;
      endcase

      irq_en    = reg_img[W_IRQEN];
      wm        = watermark_level();
      level     = fifo_img.size();
      res.irq   = (irq_en[0] && capture_running() && level >= wm) ||
                  (irq_en[1] && overflow_flag);
      res.stall = !(reg_img[W_CTL][CTL_DMA_BIT] && level >= wm);
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) $display("MISMATCH at %0t ns: %s", $time, what);
   endtask

   always @(posedge clock) begin
      capture_rsp_type want;
      bit              took;

      took = 1'b0;
      if (reset) begin
         for (int i = 0; i < REG_WORDS; i++) reg_img[i] = 32'h0;
         fifo_img.delete();
         rsp_expect_q.delete();
         last_pop      = 16'h0;
         half_owed     = 1'b0;
         overflow_flag = 1'b0;
         idle_cycles   = 0;
      end else begin
         if (rsp_valid === 1'b1) begin
            took = 1'b1;
            if (rsp_expect_q.size() == 0) begin
               report_mismatch("result arrived with no request outstanding");
            end else begin
               want = rsp_expect_q.pop_front();
               results_checked++;
               if (rsp_rdata !== want.rdata)
                  report_mismatch($sformatf("rdata %h, expected %h", rsp_rdata, want.rdata));
               if (rsp_irq !== want.irq)
                  report_mismatch($sformatf("irq %b, expected %b", rsp_irq, want.irq));
               if (rsp_dma_stall !== want.stall)
                  report_mismatch($sformatf("dma_stall %b, expected %b",
                                            rsp_dma_stall, want.stall));
            end
         end
         if (start && !busy) begin
            took = 1'b1;
            requests_taken++;
            want = predict_capture(req_func, req_addr, req_size, req_wdata, req_sample);
            if (row_typed) want = row_exp;
            rsp_expect_q.push_back(want);
         end
         if (took) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no request or result for %0d cycles", IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the request is taken.
   task automatic issue_request(input logic [1:0] func, input logic [11:0] addr,
                                input logic [2:0] size, input logic [31:0] wdata,
                                input logic [15:0] smp, input logic typed,
                                input capture_rsp_type exp);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start      <= 1'b1;
      req_func   <= func;
      req_addr   <= addr;
      req_size   <= size;
      req_wdata  <= wdata;
      req_sample <= smp;
      row_typed  <= typed;
      row_exp    <= exp;
      do @(posedge clock); while (busy !== 1'b0);
      @(negedge clock);
   endtask

   task automatic random_request();
      int unsigned pick;
      int unsigned sel;
      logic [1:0]  f;
      logic [11:0] a;
      logic [2:0]  s;
      logic [31:0] d;
      logic [15:0] smp;
      logic [9:0]  word;

      pick = $urandom_range(99);
      f    = FUNC_READ;
      a    = 12'($urandom);
      s    = 3'($urandom_range(1, 4));
      d    = $urandom;
      smp  = 16'($urandom);
      if (pick < 30) begin
         f = FUNC_SAMPLE;
      end else if (pick < 55) begin
         a   = {W_PORT, ($urandom_range(3) == 0) ? 2'($urandom) : 2'b00};
         sel = $urandom_range(9);
         s   = (sel < 4) ? 3'd2 : (sel < 8) ? 3'd4 : 3'($urandom_range(7));
      end else if (pick < 70) begin
         a = {10'($urandom_range(11)), 2'($urandom)};
      end else if (pick < 85) begin
         f   = FUNC_WRITE;
         sel = $urandom_range(3);
         case (sel)
            0: begin
               word = W_CONFIG;
               case ($urandom_range(9))
                  0: d = d | 32'h8000_0000;
                  1: d = d & 32'h7FFF_FF00;
                  default: d = (d & 32'h7FFF_FFFF) | 32'($urandom_range(1, 255));
               endcase
            end
            1: word = W_CTL;
            2: word = W_THRESH;
            default: word = W_IRQEN;
         endcase
         a = {word, 2'b00};
         s = 3'd4;
         if ($urandom_range(4) == 0) begin
            a = {word, 2'($urandom)};
            s = 3'($urandom_range(1, 3));
         end
      end else if (pick < 97) begin
         f = $urandom_range(1) ? FUNC_WRITE : FUNC_READ;
         s = 3'($urandom_range(7));
      end else begin
         f = FUNC_NONE;
         s = 3'($urandom_range(7));
      end
      issue_request(f, a, s, d, smp, 1'b0, '0);
   endtask

   initial begin
      step_row_type row;

      reset           = 1'b1;
      start           = 1'b0;
      req_func        = FUNC_READ;
      req_addr        = 12'h000;
      req_size        = 3'd0;
      req_wdata       = 32'h0;
      req_sample      = 16'sh0;
      row_typed       = 1'b0;
      row_exp         = '0;
      sender_idle_pct = 36;
      mismatch_count  = 0;
      requests_taken  = 0;
      results_checked = 0;
      reads_seen      = 0;
      writes_seen     = 0;
      samples_seen    = 0;
      pushes_done     = 0;
      pops_done       = 0;
      drops_done      = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row = DIRECTED_TABLE[i];
         issue_request(row.func, row.addr, row.size, row.wdata, row.smp, row.typed,
                       '{row.exp_rdata, row.exp_irq, row.exp_stall});
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 3) sender_idle_pct = 75;
         if (i == 2 * RANDOM_ITEMS / 3) sender_idle_pct = 0;
         random_request();
      end
      start <= 1'b0;

      while (rsp_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d requests: %0d reads, %0d writes, %0d samples;",
               requests_taken, reads_seen, writes_seen, samples_seen);
      $display("%0d results compared; FIFO saw %0d pushes, %0d pops, %0d overflow drops.",
               results_checked, pushes_done, pops_done, drops_done);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
